[src/llwg_pkg.sv]
// Shared types, constants and arithmetic helpers for the log-law wall gradient block.
// Used by every module under src except llwg_checker; depends on nothing else.
`timescale 1ns / 1ps

package llwg_pkg;

    localparam int unsigned CELL_MAX_BITS = 32;
    localparam int unsigned CFG_ADDR_BITS = 4;
    localparam int unsigned LG_STEPS      = 16;
    localparam int unsigned DIV_STEPS     = 32;
    localparam int unsigned QUEUE_DEPTH   = 4;
    localparam int unsigned QPTR_BITS     = 2;
    localparam int unsigned DEN_BITS      = 36;

    // ln 2 in unsigned Q0.32
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_SPACING_X = 4'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_SPACING_Y = 4'd1;
    localparam logic [31:0]              SPACING_RESET = 32'd65536;

    typedef enum logic [2:0] {
        MODE_BELOW = 3'd0,
        MODE_ABOVE = 3'd1,
        MODE_BACK  = 3'd2,
        MODE_FRONT = 3'd3,
        MODE_RIGHT = 3'd4,
        MODE_LEFT  = 3'd5
    } mode_t;

    localparam logic [1:0] PAIR_Z = 2'd0;
    localparam logic [1:0] PAIR_X = 2'd1;
    localparam logic [1:0] PAIR_Y = 2'd2;

    typedef struct packed {
        logic [CELL_MAX_BITS-1:0] cell_idx;
        logic [1:0]               pair;
        logic [32:0]              s1;
        logic [32:0]              s2;
        logic [31:0]              h;
        logic [31:0]              z0;
    } task_t;

    typedef struct packed {
        logic [4:0]  p;
        logic [31:0] m;
        logic [15:0] frac;
    } lg_lane_t;

    typedef struct packed {
        logic [CELL_MAX_BITS-1:0] cell_idx;
        logic [1:0]               pair;
        logic [32:0]              s1;
        logic [32:0]              s2;
        logic [DEN_BITS-1:0]      den;
        logic                     ok;
    } den_task_t;

    typedef struct packed {
        logic [DEN_BITS-1:0] rem;
        logic [31:0]         num;
        logic [31:0]         quo;
        logic                ovf;
        logic                zero;
        logic                neg;
    } div_lane_t;

    // Leading-one position and mantissa aligned to Q1.31.
    function automatic lg_lane_t lg_norm(input logic [31:0] x);
        lg_lane_t    r;
        logic [4:0]  p;
        p = '0;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) begin
                p = 5'(i);
            end
        end
        r.p    = p;
        r.m    = x << (5'd31 - p);
        r.frac = '0;
        return r;
    endfunction

    // One fraction bit of the base-2 log by squaring the mantissa.
    function automatic lg_lane_t lg_step(input lg_lane_t a);
        lg_lane_t    r;
        logic [63:0] sq;
        logic [32:0] t;
        sq     = {32'd0, a.m} * {32'd0, a.m};
        t      = sq[63:31];
        r.p    = a.p;
        r.frac = {a.frac[14:0], t[32]};
        r.m    = t[32] ? t[32:1] : t[31:0];
        return r;
    endfunction

    function automatic div_lane_t div_setup(input logic [32:0] s,
                                            input logic [DEN_BITS-1:0] den);
        div_lane_t   r;
        logic [32:0] mag;
        mag    = s[32] ? (~s + 33'd1) : s;
        r.zero = (mag == 33'd0);
        r.neg  = s[32];
        // The quotient reaches 2^32 exactly when the magnitude reaches den * 2^17.
        r.ovf  = (den == '0) || ({20'd0, mag} >= {den, 17'd0});
        r.rem  = {20'd0, mag[32:17]};
        r.num  = {mag[16:0], 15'd0};
        r.quo  = '0;
        return r;
    endfunction

    function automatic div_lane_t div_step(input div_lane_t a,
                                           input logic [DEN_BITS-1:0] den);
        div_lane_t         r;
        logic [DEN_BITS:0] r2;
        logic              qb;
        r2 = {a.rem, a.num[31]};
        qb = (r2 >= {1'b0, den});
        if (qb) begin
            r.rem = DEN_BITS'(r2 - {1'b0, den});
        end else begin
            r.rem = r2[DEN_BITS-1:0];
        end
        r.quo  = {a.quo[30:0], qb};
        r.num  = {a.num[30:0], 1'b0};
        r.ovf  = a.ovf;
        r.zero = a.zero;
        r.neg  = a.neg;
        return r;
    endfunction

    function automatic logic [31:0] div_result(input div_lane_t a);
        logic [32:0] q;
        q = a.ovf ? 33'h1_0000_0000 : {1'b0, a.quo};
        if (a.zero) begin
            return 32'd0;
        end
        if (!a.neg) begin
            if (q > 33'h0_7FFF_FFFF) begin
                q = 33'h0_7FFF_FFFF;
            end
            return q[31:0];
        end
        if (q > 33'h0_8000_0000) begin
            q = 33'h0_8000_0000;
        end
        return 32'd0 - q[31:0];
    endfunction

endpackage

[src/llwg_front.sv]
// Front end: takes input transactions, averages roughness and picks the wall spacing.
// Holds the spacing registers. Depends on llwg_pkg.
`timescale 1ns / 1ps

module llwg_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [llwg_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  logic [31:0]                          cfg_wdata,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [2:0]                           mode,
    input  logic [llwg_pkg::CELL_MAX_BITS-1:0]   cell_idx,
    input  logic [31:0]                          first_vel_a,
    input  logic [31:0]                          first_vel_b,
    input  logic [31:0]                          second_vel_a,
    input  logic [31:0]                          second_vel_b,
    input  logic [31:0]                          rough_u_west,
    input  logic [31:0]                          rough_u_east,
    input  logic [31:0]                          rough_v_south,
    input  logic [31:0]                          rough_v_north,
    input  logic [31:0]                          layer_spacing,
    output logic                                 task_valid,
    output llwg_pkg::task_t                      task_data,
    input  logic                                 task_ready
);
    import llwg_pkg::*;

    logic [31:0] spacing_x_reg;
    logic [31:0] spacing_y_reg;
    logic        valid_reg;
    logic        valid_next;
    task_t       task_reg;
    task_t       task_next;
    logic [33:0] rough_sum;
    logic [31:0] spacing;
    logic [1:0]  pair;
    logic        accept;

    assign in_ready   = !valid_reg || task_ready;
    assign accept     = in_valid && in_ready;
    assign task_valid = valid_reg;
    assign task_data  = task_reg;

    always_comb begin
        case (mode)
            MODE_BELOW, MODE_ABOVE: begin
                spacing = layer_spacing;
                pair    = PAIR_Z;
            end
            MODE_BACK, MODE_FRONT: begin
                spacing = spacing_x_reg;
                pair    = PAIR_X;
            end
            default: begin
                spacing = spacing_y_reg;
                pair    = PAIR_Y;
            end
        endcase
        rough_sum = {2'd0, rough_u_west} + {2'd0, rough_u_east}
                  + {2'd0, rough_v_south} + {2'd0, rough_v_north};
        task_next.cell_idx = cell_idx;
        task_next.pair     = pair;
        task_next.s1   = {first_vel_a[31], first_vel_a} + {first_vel_b[31], first_vel_b};
        task_next.s2   = {second_vel_a[31], second_vel_a} + {second_vel_b[31], second_vel_b};
        task_next.h    = {1'b0, spacing[31:1]};
        task_next.z0   = rough_sum[33:2];
        valid_next     = accept ? 1'b1 : (task_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spacing_x_reg <= SPACING_RESET;
            spacing_y_reg <= SPACING_RESET;
            valid_reg     <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (cfg_wr_en && cfg_addr == CFG_SPACING_X) begin
                spacing_x_reg <= cfg_wdata;
            end
            if (cfg_wr_en && cfg_addr == CFG_SPACING_Y) begin
                spacing_y_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            task_reg <= task_next;
        end
    end

endmodule

[src/llwg_queue.sv]
// Short queue that decouples the front end from the arithmetic pipeline.
// Depends on llwg_pkg.
`timescale 1ns / 1ps

module llwg_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  llwg_pkg::task_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output llwg_pkg::task_t pop_data
);
    import llwg_pkg::*;

    task_t                mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS:0]   count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign full      = (count_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[src/llwg_log.sv]
// Log pipeline: base-2 logs of half spacing and roughness, natural log difference
// and the Q20.16 denominator. Depends on llwg_pkg.
`timescale 1ns / 1ps

module llwg_log (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  logic                in_valid,
    input  llwg_pkg::task_t     in_task,
    output logic                out_valid,
    output llwg_pkg::den_task_t out_task
);
    import llwg_pkg::*;

    logic      v_reg  [LG_STEPS+1];
    task_t     tk_reg [LG_STEPS+1];
    lg_lane_t  hl_reg [LG_STEPS+1];
    lg_lane_t  zl_reg [LG_STEPS+1];

    logic      dv_reg;
    task_t     dtk_reg;
    logic [20:0] dmag_reg;
    logic      okd_reg;

    logic      lv_reg;
    task_t     ltk_reg;
    logic [20:0] l_reg;
    logic      okl_reg;

    logic      ov_reg;
    den_task_t out_reg;

    logic [21:0] d_diff;
    logic        d_ok;
    logic [52:0] l_prod;
    logic [52:0] h_prod;

    always_comb begin
        d_diff = {1'b0, hl_reg[LG_STEPS].p, hl_reg[LG_STEPS].frac}
               - {1'b0, zl_reg[LG_STEPS].p, zl_reg[LG_STEPS].frac};
        d_ok   = (tk_reg[LG_STEPS].h != '0) && (tk_reg[LG_STEPS].z0 != '0)
              && !d_diff[21] && (d_diff != '0);
        l_prod = 53'(dmag_reg) * 53'(LN2_Q32) + 53'h0_0000_8000_0000;
        h_prod = 53'(ltk_reg.h) * 53'(l_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= LG_STEPS; k++) begin
                v_reg[k] <= 1'b0;
            end
            dv_reg <= 1'b0;
            lv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else if (advance) begin
            v_reg[0] <= in_valid;
            for (int k = 1; k <= LG_STEPS; k++) begin
                v_reg[k] <= v_reg[k-1];
            end
            dv_reg <= v_reg[LG_STEPS];
            lv_reg <= dv_reg;
            ov_reg <= lv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            tk_reg[0] <= in_task;
            hl_reg[0] <= lg_norm(in_task.h);
            zl_reg[0] <= lg_norm(in_task.z0);
            for (int k = 1; k <= LG_STEPS; k++) begin
                tk_reg[k] <= tk_reg[k-1];
                hl_reg[k] <= lg_step(hl_reg[k-1]);
                zl_reg[k] <= lg_step(zl_reg[k-1]);
            end
            dtk_reg  <= tk_reg[LG_STEPS];
            dmag_reg <= d_diff[20:0];
            okd_reg  <= d_ok;

            ltk_reg <= dtk_reg;
            l_reg   <= l_prod[52:32];
            okl_reg <= okd_reg;

            out_reg.cell_idx <= ltk_reg.cell_idx;
            out_reg.pair     <= ltk_reg.pair;
            out_reg.s1   <= ltk_reg.s1;
            out_reg.s2   <= ltk_reg.s2;
            out_reg.den  <= h_prod[51:16];
            out_reg.ok   <= okl_reg && (l_reg != '0);
        end
    end

    assign out_valid = ov_reg;
    assign out_task  = out_reg;

endmodule

[src/llwg_div.sv]
// Divider pipeline: one quotient bit per stage for both gradients, saturation,
// and the output register. Depends on llwg_pkg.
`timescale 1ns / 1ps

module llwg_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    input  llwg_pkg::den_task_t               in_task,
    output logic                              advance,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [llwg_pkg::CELL_MAX_BITS-1:0] out_cell,
    output logic [1:0]                        out_pair,
    output logic [31:0]                       out_grad_first,
    output logic [31:0]                       out_grad_second,
    output logic                              out_bad
);
    import llwg_pkg::*;

    logic      v_reg  [DIV_STEPS+1];
    den_task_t dt_reg [DIV_STEPS+1];
    div_lane_t a_reg  [DIV_STEPS+1];
    div_lane_t b_reg  [DIV_STEPS+1];

    logic                     mv_reg;
    logic [CELL_MAX_BITS-1:0] cell_reg;
    logic [1:0]               pair_reg;
    logic [31:0]              g1_reg;
    logic [31:0]              g2_reg;
    logic                     bad_reg;

    // The whole pipeline moves whenever the output register can take a transaction.
    assign advance = !mv_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= DIV_STEPS; k++) begin
                v_reg[k] <= 1'b0;
            end
            mv_reg <= 1'b0;
        end else if (advance) begin
            v_reg[0] <= in_valid;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                v_reg[k] <= v_reg[k-1];
            end
            mv_reg <= v_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            dt_reg[0] <= in_task;
            a_reg[0]  <= div_setup(in_task.s1, in_task.den);
            b_reg[0]  <= div_setup(in_task.s2, in_task.den);
            for (int k = 1; k <= DIV_STEPS; k++) begin
                dt_reg[k] <= dt_reg[k-1];
                a_reg[k]  <= div_step(a_reg[k-1], dt_reg[k-1].den);
                b_reg[k]  <= div_step(b_reg[k-1], dt_reg[k-1].den);
            end
            cell_reg <= dt_reg[DIV_STEPS].cell_idx;
            pair_reg <= dt_reg[DIV_STEPS].pair;
            bad_reg  <= !dt_reg[DIV_STEPS].ok;
            g1_reg   <= dt_reg[DIV_STEPS].ok ? div_result(a_reg[DIV_STEPS]) : 32'd0;
            g2_reg   <= dt_reg[DIV_STEPS].ok ? div_result(b_reg[DIV_STEPS]) : 32'd0;
        end
    end

    assign out_valid       = mv_reg;
    assign out_cell        = cell_reg;
    assign out_pair        = pair_reg;
    assign out_grad_first  = g1_reg;
    assign out_grad_second = g2_reg;
    assign out_bad         = bad_reg;

endmodule

[src/loglaw_wall_gradient.sv]
// Log-law wall gradient unit, top level.
// Wall-face records enter on the s_ stream, one result per record leaves on the
// m_ stream. Spacing registers are written through cfg_wr_en / cfg_addr / cfg_wdata
// (index 0 spacing_x, index 1 spacing_y, other indices ignored); the user must write
// them only while idle, as the block itself does not enforce it. A record accepted
// on s_ passes the front end, the queue, the 16 squaring stages of the log pipeline,
// the log difference stages, the 32 stages of the restoring divider and the output
// register. One record is accepted per cycle in steady state while m_tready is high.
// A four-entry queue sits between the front end and the arithmetic pipeline; when
// m_tready is low with a result on m_, the pipeline and output register hold, the
// queue fills and then s_tready falls.
// Reset (aresetn low, synchronous) empties the pipeline and queue and sets both
// spacing registers to 1.0 in Q16.16.
// Depends on llwg_pkg, llwg_front, llwg_queue, llwg_log and llwg_div.
`timescale 1ns / 1ps

module loglaw_wall_gradient #(
    parameter int CELL_INDEX_BITS = 24,
    localparam int S_TDATA_W = ((CELL_INDEX_BITS + 9 * 32 + 7) / 8) * 8,
    localparam int M_TDATA_W = ((CELL_INDEX_BITS + 2 * 32 + 7) / 8) * 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [llwg_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [31:0]                         cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // cell_index, first_vel_a, first_vel_b, second_vel_a, second_vel_b,
    // rough_u_west, rough_u_east, rough_v_south, rough_v_north, layer_spacing
    input  logic [S_TDATA_W-1:0]                s_tdata,
    // mode
    input  logic [2:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // cell_out, grad_first, grad_second
    output logic [M_TDATA_W-1:0]                m_tdata,
    // component_pair, bad_roughness
    output logic [2:0]                          m_tuser
);
    import llwg_pkg::*;

    localparam int C = CELL_INDEX_BITS;

    logic                     task_valid;
    task_t                    task_data;
    logic                     q_full;
    logic                     q_not_empty;
    task_t                    q_data;
    logic                     advance;
    logic                     den_valid;
    den_task_t                den_task;
    logic [CELL_MAX_BITS-1:0] out_cell;
    logic [1:0]               out_pair;
    logic [31:0]              grad_first;
    logic [31:0]              grad_second;
    logic                     out_bad;

    llwg_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .mode          (s_tuser),
        .cell_idx      (CELL_MAX_BITS'(s_tdata[C-1:0])),
        .first_vel_a   (s_tdata[C       +: 32]),
        .first_vel_b   (s_tdata[C + 32  +: 32]),
        .second_vel_a  (s_tdata[C + 64  +: 32]),
        .second_vel_b  (s_tdata[C + 96  +: 32]),
        .rough_u_west  (s_tdata[C + 128 +: 32]),
        .rough_u_east  (s_tdata[C + 160 +: 32]),
        .rough_v_south (s_tdata[C + 192 +: 32]),
        .rough_v_north (s_tdata[C + 224 +: 32]),
        .layer_spacing (s_tdata[C + 256 +: 32]),
        .task_valid    (task_valid),
        .task_data     (task_data),
        .task_ready    (!q_full)
    );

    llwg_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (task_valid),
        .push_data (task_data),
        .full      (q_full),
        .pop       (advance),
        .not_empty (q_not_empty),
        .pop_data  (q_data)
    );

    llwg_log u_log (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (q_not_empty),
        .in_task   (q_data),
        .out_valid (den_valid),
        .out_task  (den_task)
    );

    llwg_div u_div (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (den_valid),
        .in_task         (den_task),
        .advance         (advance),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_cell        (out_cell),
        .out_pair        (out_pair),
        .out_grad_first  (grad_first),
        .out_grad_second (grad_second),
        .out_bad         (out_bad)
    );

    always_comb begin
        m_tdata              = '0;
        m_tdata[C-1:0]       = out_cell[C-1:0];
        m_tdata[C +: 32]     = grad_first;
        m_tdata[C + 32 +: 32] = grad_second;
        m_tuser              = {out_bad, out_pair};
    end

endmodule

[src/llwg_checker.sv]
// Port-level checks for the log-law wall gradient unit, bound to the top level.
// Depends on loglaw_wall_gradient.
`timescale 1ns / 1ps

module llwg_checker #(
    parameter int CELL_INDEX_BITS = 24,
    localparam int M_TDATA_W = ((CELL_INDEX_BITS + 2 * 32 + 7) / 8) * 8
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [2:0]           m_tuser
);

    // A stalled result transaction holds its payload.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_pair_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[1:0] != 2'd3)
        else $error("component pair code out of range");

    // A record flagged for bad roughness carries zero gradients.
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tdata[CELL_INDEX_BITS +: 64] == 64'd0)
        else $error("bad roughness with non-zero gradient");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

endmodule

bind loglaw_wall_gradient llwg_checker #(
    .CELL_INDEX_BITS(CELL_INDEX_BITS)
) u_llwg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
